>>> design/pidff_pkg.sv
// Shared types and widths for the PID step unit with feed-forward.
// Used by pidff_term and pid_feedforward_step_unit; no dependencies.
`default_nettype none

package pidff_pkg;

  localparam int DATA_W     = 32;
  localparam int LIMIT_W    = 31;
  localparam int ESUM_W     = 48;
  localparam int ESUM_SPLIT = 24;
  localparam int PROD_W     = 80;
  localparam int TERM_W     = 62;
  localparam int TERM_EXP   = 60;
  localparam int SUM_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int STAGES     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP        = 3'd0,
    REG_KI_STEP   = 3'd1,
    REG_KD_RATE   = 3'd2,
    REG_FF_OFFSET = 3'd3,
    REG_FF1_RATE  = 3'd4,
    REG_FF2_RATE  = 3'd5,
    REG_OUT_LIMIT = 3'd6
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> design/pidff_term.sv
// Product term scaling: floor shift by the fraction width, saturate to +/- 2^60.
// Depends on pidff_pkg for the product and term widths.
`default_nettype none

module pidff_term #(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [pidff_pkg::PROD_W-1:0] prod_i,
  output logic signed [pidff_pkg::TERM_W-1:0] term_o
);

  localparam int ProdW = pidff_pkg::PROD_W;
  localparam int TermW = pidff_pkg::TERM_W;
  localparam logic signed [ProdW-1:0] TermMax =
    {{(ProdW - pidff_pkg::TERM_EXP - 1){1'b0}}, 1'b1, {pidff_pkg::TERM_EXP{1'b0}}};
  localparam logic signed [ProdW-1:0] TermMin = -TermMax;

  logic signed [ProdW-1:0] shifted;

  always_comb begin
    shifted = prod_i >>> FRAC_BITS;
    if (shifted > TermMax) begin
      term_o = TermMax[TermW-1:0];
    end else if (shifted < TermMin) begin
      term_o = TermMin[TermW-1:0];
    end else begin
      term_o = shifted[TermW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> design/pid_feedforward_step_unit.sv
// PID step unit with feed-forward: state update, product pipeline, sum and clamp.
// Depends on pidff_pkg and pidff_term.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   target_i, measured_i, clear_history_i
//   out      output     out_valid_o / out_stall_i drive_o, clamped_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One word per cycle while out_stall_i is low; out_valid_o marks the drive register.
// History (error sum, last error/target/step) updates at accept in one add step,
// so the integrator loop sets the one-cycle rate; products fill stages 2 to 5.
// Reset clears history and valid bits and loads register defaults.
// Output stall holds the result; empty stages absorb new words until full.
`default_nettype none

module pid_feedforward_step_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] target_i,
  input  logic [31:0] measured_i,
  input  logic        clear_history_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] drive_o,
  output logic        clamped_o
);

  localparam int ProdW = pidff_pkg::PROD_W;
  localparam int TermW = pidff_pkg::TERM_W;
  localparam int SumW  = pidff_pkg::SUM_W;
  localparam int EsW   = pidff_pkg::ESUM_W;
  localparam int Split = pidff_pkg::ESUM_SPLIT;
  localparam int Stg   = pidff_pkg::STAGES;

  logic signed [31:0] kp_q, ki_q, kd_q, ffo_q, ff1_q, ff2_q;
  logic [30:0]        limit_q;

  logic [EsW-1:0] esum_q, esum_d;
  logic [31:0]    lerr_q, lerr_d;
  logic [31:0]    ltgt_q, ltgt_d;
  logic [32:0]    lstep_q, lstep_d;

  logic [Stg-1:0] v_q, v_d, en;
  logic           in_fire;

  logic [32:0]    diff;
  logic [EsW:0]   esum_wide;
  logic [31:0]    e_d;
  logic [32:0]    s_d, de_d;
  logic [33:0]    ds_d;
  logic [EsW-1:0] es_base;
  logic [31:0]    le_base, lt_base;
  logic [32:0]    ls_base;

  logic [31:0]    e_a_q;
  logic [EsW-1:0] es_a_q;
  logic [32:0]    de_a_q, s_a_q;
  logic [33:0]    ds_a_q;

  logic signed [63:0] pkp_q;
  logic signed [64:0] pkd_q, pf1_q;
  logic signed [65:0] pf2_q;
  logic signed [56:0] pkil_q;
  logic signed [55:0] pkih_q;
  logic signed [ProdW-1:0] ki_full;

  logic signed [TermW-1:0] t_kp, t_ki, t_kd, t_f1, t_f2;
  logic signed [TermW-1:0] t_kp_q, t_ki_q, t_kd_q, t_f1_q, t_f2_q;

  logic signed [SumW-1:0] sum_d, sum_q, lim_pos;
  logic [31:0] drive_d;
  logic        clamped_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      ffo_q   <= '0;
      ff1_q   <= '0;
      ff2_q   <= '0;
      limit_q <= 31'h7fff_ffff;
    end else if (cfg_we_i) begin
      case (pidff_pkg::cfg_reg_e'(cfg_idx_i))
        pidff_pkg::REG_KP:        kp_q    <= cfg_wdata_i;
        pidff_pkg::REG_KI_STEP:   ki_q    <= cfg_wdata_i;
        pidff_pkg::REG_KD_RATE:   kd_q    <= cfg_wdata_i;
        pidff_pkg::REG_FF_OFFSET: ffo_q   <= cfg_wdata_i;
        pidff_pkg::REG_FF1_RATE:  ff1_q   <= cfg_wdata_i;
        pidff_pkg::REG_FF2_RATE:  ff2_q   <= cfg_wdata_i;
        pidff_pkg::REG_OUT_LIMIT: limit_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[Stg-1] = !v_q[Stg-1] || !out_stall_i;
    for (int k = Stg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < Stg; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  assign in_stall_o = !en[0];
  assign in_fire    = in_valid_i && en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_comb begin
    es_base = clear_history_i ? '0 : esum_q;
    le_base = clear_history_i ? '0 : lerr_q;
    lt_base = clear_history_i ? '0 : ltgt_q;
    ls_base = clear_history_i ? '0 : lstep_q;

    diff = {target_i[31], target_i} - {measured_i[31], measured_i};
    if (diff[32] != diff[31]) begin
      e_d = diff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      e_d = diff[31:0];
    end

    esum_wide = {es_base[EsW-1], es_base} + {{(EsW - 31){e_d[31]}}, e_d};
    if (esum_wide[EsW] != esum_wide[EsW-1]) begin
      esum_d = esum_wide[EsW] ? {1'b1, {(EsW - 1){1'b0}}} : {1'b0, {(EsW - 1){1'b1}}};
    end else begin
      esum_d = esum_wide[EsW-1:0];
    end

    s_d     = {target_i[31], target_i} - {lt_base[31], lt_base};
    ds_d    = {s_d[32], s_d} - {ls_base[32], ls_base};
    de_d    = {e_d[31], e_d} - {le_base[31], le_base};
    lerr_d  = e_d;
    ltgt_d  = target_i;
    lstep_d = s_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q  <= '0;
      lerr_q  <= '0;
      ltgt_q  <= '0;
      lstep_q <= '0;
    end else if (in_fire) begin
      esum_q  <= esum_d;
      lerr_q  <= lerr_d;
      ltgt_q  <= ltgt_d;
      lstep_q <= lstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      e_a_q  <= e_d;
      es_a_q <= esum_d;
      de_a_q <= de_d;
      s_a_q  <= s_d;
      ds_a_q <= ds_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pkp_q  <= kp_q * $signed(e_a_q);
      pkd_q  <= kd_q * $signed(de_a_q);
      pf1_q  <= ff1_q * $signed(s_a_q);
      pf2_q  <= ff2_q * $signed(ds_a_q);
      pkil_q <= ki_q * $signed({1'b0, es_a_q[Split-1:0]});
      pkih_q <= ki_q * $signed(es_a_q[EsW-1:Split]);
    end
  end

  assign ki_full = (ProdW'(pkih_q) <<< Split) + ProdW'(pkil_q);

  pidff_term #(.FRAC_BITS(FRAC_BITS)) u_term_kp (.prod_i(ProdW'(pkp_q)), .term_o(t_kp));
  pidff_term #(.FRAC_BITS(FRAC_BITS)) u_term_ki (.prod_i(ki_full), .term_o(t_ki));
  pidff_term #(.FRAC_BITS(FRAC_BITS)) u_term_kd (.prod_i(ProdW'(pkd_q)), .term_o(t_kd));
  pidff_term #(.FRAC_BITS(FRAC_BITS)) u_term_f1 (.prod_i(ProdW'(pf1_q)), .term_o(t_f1));
  pidff_term #(.FRAC_BITS(FRAC_BITS)) u_term_f2 (.prod_i(ProdW'(pf2_q)), .term_o(t_f2));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      t_kp_q <= t_kp;
      t_ki_q <= t_ki;
      t_kd_q <= t_kd;
      t_f1_q <= t_f1;
      t_f2_q <= t_f2;
    end
  end

  assign sum_d = SumW'(t_kp_q) + SumW'(t_ki_q) + SumW'(t_kd_q)
               + SumW'(ffo_q) + SumW'(t_f1_q) + SumW'(t_f2_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sum_q <= sum_d;
    end
  end

  always_comb begin
    lim_pos = $signed({{(SumW - 31){1'b0}}, limit_q});
    if (sum_q > lim_pos) begin
      drive_d   = {1'b0, limit_q};
      clamped_d = 1'b1;
    end else if (sum_q < -lim_pos) begin
      drive_d   = 32'd0 - {1'b0, limit_q};
      clamped_d = 1'b1;
    end else begin
      drive_d   = sum_q[31:0];
      clamped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      drive_o   <= drive_d;
      clamped_o <= clamped_d;
    end
  end

  assign out_valid_o = v_q[Stg-1];

`ifndef NO_ASSERTIONS
  a_clamp_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_o |->
      (drive_o == {1'b0, limit_q}) || (drive_o == 32'd0 - {1'b0, limit_q}))
    else $error("clamped drive is not at the limit");

  a_inside_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !clamped_o |->
      ($signed(drive_o) <= $signed({1'b0, limit_q})) &&
      ($signed(drive_o) >= -$signed({1'b0, limit_q})))
    else $error("unclamped drive exceeds the limit");

  a_clear_restarts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && clear_history_i |=> es_a_q == {{(EsW - 32){e_a_q[31]}}, e_a_q})
    else $error("error sum not restarted by clear");
`endif

endmodule

`default_nettype wire

>>> dv/pid_feedforward_step_unit_tb.sv
// Self-checking testbench for pid_feedforward_step_unit: a directed table, an integrator
// wind-up run and random control trajectories, checked against a predictor or table rows.
// Depends on pidff_pkg and the pid_feedforward_step_unit RTL.
`default_nettype none

module pid_feedforward_step_unit_tb;

  localparam int          FRAC_BITS      = 16;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          LONG_HOLD      = 40;
  localparam int          RAND_PHASES    = 6;
  localparam int          PHASE_WORDS    = 235;
  localparam int          WINDUP_WORDS   = 16;
  localparam logic [2:0]  REG_UNUSED     = 3'd7;

  localparam logic signed [79:0] TERM_LIM = 80'sh1000_0000_0000_0000;
  localparam logic signed [32:0] ERR_MAX  = 33'sd2147483647;
  localparam logic signed [32:0] ERR_MIN  = -33'sd2147483648;
  localparam logic signed [48:0] ESUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] ESUM_MIN = -49'sh0_8000_0000_0000;

  typedef struct packed {
    logic [31:0] drive;
    logic        clamped;
  } drive_word_t;

  typedef enum logic [1:0] {
    ROW_STEP,
    ROW_CHECK,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] a;
    logic [31:0] b;
    logic        clr;
    logic [31:0] exp_drive;
    logic        exp_clamped;
  } stim_row_t;

  localparam int DIR_N = 36;

  stim_row_t dir_rows [DIR_N] = '{
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, REG_UNUSED, 32'h1234_5678, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h0001_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_KP, 32'h0001_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0001, 1'b1},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h0003_0000, 32'h0001_0000, 1'b0, 32'h0002_0000, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_OUT_LIMIT, 32'h0001_8000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h0003_0000, 32'h0001_0000, 1'b0, 32'h0001_8000, 1'b1},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h0001_0000, 32'h0003_0000, 1'b0, 32'hFFFE_8000, 1'b1},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h0001_8000, 32'h0000_0000, 1'b0, 32'h0001_8000, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_OUT_LIMIT, 32'h0000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h0005_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1},
    '{ROW_CHECK, pidff_pkg::REG_KP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_OUT_LIMIT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_KP, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_KI_STEP, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_KD_RATE, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_FF_OFFSET, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_FF1_RATE, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_FF2_RATE, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_STEP,  pidff_pkg::REG_KP, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 1'b0},
    '{ROW_STEP,  pidff_pkg::REG_KP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_STEP,  pidff_pkg::REG_KP, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_STEP,  pidff_pkg::REG_KP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_KP, 32'h0000_8000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_KI_STEP, 32'h0000_0100, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_KD_RATE, 32'hFFFF_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_FF_OFFSET, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_FF1_RATE, 32'h0000_0003, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_FF2_RATE, 32'hFFFF_FFFD, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pidff_pkg::REG_OUT_LIMIT, 32'h0064_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_STEP,  pidff_pkg::REG_KP, 32'h0000_0001, 32'h0000_0002, 1'b1, 32'h0, 1'b0},
    '{ROW_STEP,  pidff_pkg::REG_KP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_STEP,  pidff_pkg::REG_KP, 32'h0010_0000, 32'hFFF0_0000, 1'b0, 32'h0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] target_i;
  logic [31:0] measured_i;
  logic        clear_history_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] drive_o;
  logic        clamped_o;

  logic signed [31:0] kp_g     = '0;
  logic signed [31:0] ki_g     = '0;
  logic signed [31:0] kd_g     = '0;
  logic signed [31:0] ff0_g    = '0;
  logic signed [31:0] ff1_g    = '0;
  logic signed [31:0] ff2_g    = '0;
  logic        [30:0] limit_g  = 31'h7FFF_FFFF;
  logic signed [47:0] integ_acc = '0;
  logic signed [31:0] prev_err  = '0;
  logic signed [31:0] prev_tgt  = '0;
  logic signed [32:0] prev_step = '0;

  drive_word_t pending_drive[$];
  int          err_count  = 0;
  int          idle_cycles = 0;
  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;

  pid_feedforward_step_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .target_i       (target_i),
    .measured_i     (measured_i),
    .clear_history_i(clear_history_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .clamped_o      (clamped_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic signed [63:0] scaled_product(input logic signed [31:0] gain,
                                                        input logic signed [47:0] x);
    logic signed [79:0] ge;
    logic signed [79:0] xe;
    logic signed [79:0] q;
    ge = gain;
    xe = x;
    q  = (ge * xe) >>> FRAC_BITS;
    if (q > TERM_LIM) begin
      q = TERM_LIM;
    end else if (q < -TERM_LIM) begin
      q = -TERM_LIM;
    end
    return q[63:0];
  endfunction

  task automatic predict_drive(input logic signed [31:0] tgt, input logic signed [31:0] meas,
                               input logic clr, output drive_word_t res);
    logic signed [32:0] diff;
    logic signed [31:0] err;
    logic signed [48:0] acc;
    logic signed [32:0] step;
    logic signed [63:0] sum;
    logic signed [63:0] lim;
    if (clr) begin
      integ_acc = '0;
      prev_err  = '0;
      prev_tgt  = '0;
      prev_step = '0;
    end
    diff = tgt - meas;
    if (diff > ERR_MAX) begin
      err = ERR_MAX[31:0];
    end else if (diff < ERR_MIN) begin
      err = ERR_MIN[31:0];
    end else begin
      err = diff[31:0];
    end
    acc = integ_acc + err;
    if (acc > ESUM_MAX) begin
      acc = ESUM_MAX;
    end else if (acc < ESUM_MIN) begin
      acc = ESUM_MIN;
    end
    integ_acc = acc[47:0];
    step = tgt - prev_tgt;
    sum = scaled_product(kp_g, err) + scaled_product(ki_g, integ_acc)
        + scaled_product(kd_g, err - prev_err) + ff0_g
        + scaled_product(ff1_g, step) + scaled_product(ff2_g, step - prev_step);
    lim = {33'b0, limit_g};
    if (sum > lim) begin
      res = '{lim[31:0], 1'b1};
    end else if (sum < -lim) begin
      lim = -lim;
      res = '{lim[31:0], 1'b1};
    end else begin
      res = '{sum[31:0], 1'b0};
    end
    prev_err  = err;
    prev_step = step;
    prev_tgt  = tgt;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      pidff_pkg::REG_KP:        kp_g    = data;
      pidff_pkg::REG_KI_STEP:   ki_g    = data;
      pidff_pkg::REG_KD_RATE:   kd_g    = data;
      pidff_pkg::REG_FF_OFFSET: ff0_g   = data;
      pidff_pkg::REG_FF1_RATE:  ff1_g   = data;
      pidff_pkg::REG_FF2_RATE:  ff2_g   = data;
      pidff_pkg::REG_OUT_LIMIT: limit_g = data[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic push_word(input logic [31:0] tgt, input logic [31:0] meas, input logic clr,
                           input logic typed, input drive_word_t typed_word);
    drive_word_t pred;
    predict_drive(tgt, meas, clr, pred);
    in_valid_i      <= 1'b1;
    target_i        <= tgt;
    measured_i      <= meas;
    clear_history_i <= clr;
    do @(posedge clk_i); while (in_stall_o);
    pending_drive.push_back(typed ? typed_word : pred);
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i      <= 1'b0;
      target_i        <= $urandom;
      measured_i      <= $urandom;
      clear_history_i <= $urandom_range(0, 1);
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_gain();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'h0000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = $urandom;
      default: v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_limit();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'h0000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'hFFFF_FFFF;
      3: v = $urandom;
      default: v = $urandom_range(0, 32'h00FF_FFFF);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    drive_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("drive word with nothing pending", drive_o, '0);
      end else begin
        want = pending_drive.pop_front();
        if (drive_o !== want.drive) report_mismatch("drive", drive_o, want.drive);
        if (clamped_o !== want.clamped) begin
          report_mismatch("clamped", {31'b0, clamped_o}, {31'b0, want.clamped});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pid_feedforward_step_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          pos;
    int          vel;
    int unsigned pick;
    logic [31:0] tgt;
    logic [31:0] meas;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = pidff_pkg::REG_KP;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    target_i        = '0;
    measured_i      = '0;
    clear_history_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(dir_rows[r].idx, dir_rows[r].a);
      end else begin
        cfg_we_i <= 1'b0;
        push_word(dir_rows[r].a, dir_rows[r].b, dir_rows[r].clr, dir_rows[r].kind == ROW_CHECK,
                  '{dir_rows[r].exp_drive, dir_rows[r].exp_clamped});
        idle_gap();
      end
    end

    // push the integrator hard both ways
    for (int d = 0; d < 2; d++) begin
      wait_drained();
      write_reg(pidff_pkg::REG_KI_STEP, d == 0 ? 32'h7FFF_FFFF : 32'h8000_0000);
      write_reg(pidff_pkg::REG_KP, $urandom);
      write_reg(pidff_pkg::REG_OUT_LIMIT, 32'h7FFF_FFFF);
      cfg_we_i <= 1'b0;
      for (int i = 0; i < WINDUP_WORDS; i++) begin
        if (d == 0) begin
          tgt  = 32'h7FFF_FFFF - $urandom_range(0, 255);
          meas = 32'h8000_0000 + $urandom_range(0, 255);
        end else begin
          tgt  = 32'h8000_0000 + $urandom_range(0, 255);
          meas = 32'h7FFF_FFFF - $urandom_range(0, 255);
        end
        push_word(tgt, meas, i == 0, 1'b0, '0);
        idle_gap();
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      quiet = (ph == RAND_PHASES - 1);
      write_reg(pidff_pkg::REG_KP, rand_gain());
      write_reg(pidff_pkg::REG_KI_STEP, rand_gain());
      write_reg(pidff_pkg::REG_KD_RATE, rand_gain());
      write_reg(pidff_pkg::REG_FF_OFFSET, rand_gain());
      write_reg(pidff_pkg::REG_FF1_RATE, rand_gain());
      write_reg(pidff_pkg::REG_FF2_RATE, rand_gain());
      write_reg(pidff_pkg::REG_OUT_LIMIT, rand_limit());
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
      cfg_we_i <= 1'b0;
      pos = $urandom;
      vel = 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        pick = $urandom_range(0, 99);
        vel  = vel + int'($urandom_range(0, 511)) - 256;
        pos  = pos + vel;
        tgt  = pos;
        meas = pos + int'($urandom_range(0, 8191)) - 4096;
        if (pick >= 80 && pick < 90) begin
          tgt  = $urandom;
          meas = $urandom;
        end else if (pick >= 90 && pick < 95) begin
          tgt  = pick_extreme();
          meas = pick_extreme();
        end else if (pick >= 95) begin
          meas = tgt;
        end
        push_word(tgt, meas, $urandom_range(0, 24) == 0, 1'b0, '0);
        if (ph == 1 && i == 20) hold_req = 1'b1;
        if (ph == 2 && i == PHASE_WORDS / 2) begin
          wait_drained();
        end else begin
          idle_gap();
        end
      end
    end

    wait_drained();
    repeat (2 * pidff_pkg::STAGES) @(posedge clk_i);
    if (err_count == 0 && pending_drive.size() == 0) begin
      $display("pid_feedforward_step_unit: match");
    end else begin
      $display("pid_feedforward_step_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
design/pidff_pkg.sv
design/pidff_term.sv
design/pid_feedforward_step_unit.sv
dv/pid_feedforward_step_unit_tb.sv
